FILE: rtl/space_vector_pwm_modulator_assert.svh
// ----------------------------------------------------------------------------
// Space vector PWM modulator assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SPACE_VECTOR_PWM_MODULATOR_ASSERT_SVH
`define SPACE_VECTOR_PWM_MODULATOR_ASSERT_SVH

// same-cycle implication
`define SVPWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svpwm assertion failed");

// next-cycle implication
`define SVPWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svpwm assertion failed");

`endif

FILE: rtl/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// Space vector PWM package
// Types, widths and lookup functions of the space vector PWM modulator.
// ----------------------------------------------------------------------------
`default_nettype none

package svpwm_pkg;

    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 144;
    localparam int unsigned CFG_W       = 16;

    localparam int unsigned NW          = 36;
    localparam int unsigned NUMW        = 53;
    localparam int unsigned QW          = 17;
    localparam int unsigned DIV_STAGES  = QW;
    localparam int unsigned LANES       = 3;

    localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;

    localparam logic [CFG_W-1:0] BUS_VOLTAGE_RST  = 16'd19968;
    localparam logic [CFG_W-1:0] PERIOD_TICKS_RST = 16'd10000;

    localparam logic CFG_BUS_VOLTAGE  = 1'b0;
    localparam logic CFG_PERIOD_TICKS = 1'b1;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    typedef struct packed {
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        t_sector            sector;
        logic               lim;
    } t_pl;

    function automatic logic [2:0] first_vec(t_sector s);
        logic [2:0] v;
        unique case (s)
            SEC_0:   v = 3'b100;
            SEC_1:   v = 3'b110;
            SEC_2:   v = 3'b010;
            SEC_3:   v = 3'b011;
            SEC_4:   v = 3'b001;
            SEC_5:   v = 3'b101;
            default: v = 3'b100;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] second_vec(t_sector s);
        logic [2:0] v;
        unique case (s)
            SEC_0:   v = 3'b110;
            SEC_1:   v = 3'b010;
            SEC_2:   v = 3'b011;
            SEC_3:   v = 3'b001;
            SEC_4:   v = 3'b101;
            SEC_5:   v = 3'b100;
            default: v = 3'b110;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/space_vector_pwm_modulator.sv
// ----------------------------------------------------------------------------
// Space vector PWM modulator
// Sector search, dwell times, hexagon limiting and per-phase on-times.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one reference item (alpha, beta); master stream
//   returns one result item for each, in order. Config writes (bus voltage,
//   period) go through the plain write port; the user must make them only
//   while the block is idle, which the block itself leaves unchecked. The
//   path has 23 register stages: five of multiply, sector and numerator
//   work, seventeen restoring divider stages (one quotient bit each, three
//   lanes side by side) and the output register. Throughput is one item per
//   cycle while the receiver accepts; the divider is fully pipelined.
//   Reset clears all valid bits and loads the default bus voltage and period.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and o_s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module space_vector_pwm_modulator (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wen,
    input  wire                                i_cfg_addr,
    input  wire  [svpwm_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // ref_alpha[15:0], ref_beta[31:16]
    input  wire  [svpwm_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // sector[2:0], first_vector[5:3], second_vector[8:6], dwell_first[24:9],
    // dwell_second[40:25], dwell_zero[56:41], on_time_a[72:57],
    // on_time_b[88:73], on_time_c[104:89], out_alpha[120:105],
    // out_beta[136:121], was_limited[137], zero fill[143:138]
    output logic [svpwm_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    import svpwm_pkg::*;

    logic [CFG_W-1:0]  r_bus;
    logic [CFG_W-1:0]  r_period;
    logic              w_en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus    <= BUS_VOLTAGE_RST;
            r_period <= PERIOD_TICKS_RST;
        end else if (i_cfg_wen) begin
            if (i_cfg_addr == CFG_BUS_VOLTAGE) begin
                r_bus <= i_cfg_wdata;
            end else begin
                r_period <= i_cfg_wdata;
            end
        end
    end

    // ---------------- stage 1: products ----------------
    logic                r_v1;
    logic signed [15:0]  r1_a, r1_b;
    logic signed [31:0]  r1_aa, r1_bb;
    logic signed [33:0]  r1_bq;

    // ---------------- stage 2: sector, signed numerators ----------------
    logic                r_v2;
    logic signed [15:0]  r2_a, r2_b;
    t_sector             r2_s;
    logic signed [NW-1:0] r2_n1s, r2_n2s;
    logic [32:0]         n2_aa3;
    logic [31:0]         n2_bb;
    logic                n2_lt, n2_le, n2_up;
    t_sector             n2_s;
    logic signed [NW-1:0] n2_av, n2_bv, n2_n1s, n2_n2s;

    // ---------------- stage 3: clamp and sum ----------------
    logic                r_v3;
    logic signed [15:0]  r3_a, r3_b;
    t_sector             r3_s;
    logic [NW-2:0]       r3_n1;
    logic [NW-1:0]       r3_nsum;
    logic [32:0]         r3_d;
    logic [15:0]         r3_dsel;
    logic [NW-2:0]       n3_n1, n3_n2;
    logic [15:0]         n3_dsel;

    // ---------------- stage 4: limit, numerators ----------------
    logic                r_v4;
    t_pl                 r4_pl;
    logic [NW-1:0]       r4_den;
    logic [NUMW-1:0]     r4_num [0:LANES-1];
    logic                n4_lim;
    logic [15:0]         n4_ma, n4_mb;
    logic [31:0]         n4_pa, n4_pb;

    // ---------------- divider ----------------
    logic                r_dv_valid [0:DIV_STAGES];
    t_pl                 r_dv_pl    [0:DIV_STAGES];
    logic [NW-1:0]       r_dv_den   [0:DIV_STAGES];
    logic [NUMW-1:0]     r_dv_rem   [0:DIV_STAGES][0:LANES-1];
    logic [QW-1:0]       r_dv_q     [0:DIV_STAGES][0:LANES-1];
    logic [NUMW-1:0]     n_dv_rem   [0:DIV_STAGES-1][0:LANES-1];
    logic [QW-1:0]       n_dv_q     [0:DIV_STAGES-1][0:LANES-1];

    // ---------------- output ----------------
    logic                r_out_valid;
    t_sector             r_out_sector;
    logic [2:0]          r_out_v1, r_out_v2;
    logic [15:0]         r_out_t1, r_out_t2, r_out_t0;
    logic [15:0]         r_out_ona, r_out_onb, r_out_onc;
    logic signed [15:0]  r_out_alpha, r_out_beta;
    logic                r_out_lim;

    logic [QW-1:0]       n_q0, n_q1, n_q2, n_tot;
    logic [QW-1:0]       n_per17;
    logic [15:0]         n_t1, n_t2, n_t0;
    logic signed [15:0]  n_oa, n_ob;
    logic [2:0]          n_v1, n_v2;
    t_pl                 n_pl;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // stage 1
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a  <= i_s_axis_tdata[15:0];
            r1_b  <= i_s_axis_tdata[31:16];
            r1_aa <= $signed(i_s_axis_tdata[15:0]) * $signed(i_s_axis_tdata[15:0]);
            r1_bb <= $signed(i_s_axis_tdata[31:16]) * $signed(i_s_axis_tdata[31:16]);
            r1_bq <= 34'(SQRT3_Q16 * $signed(i_s_axis_tdata[31:16]));
        end
    end

    // stage 2
    always_comb begin
        n2_aa3 = {r1_aa, 1'b0} + {1'b0, r1_aa};
        n2_bb  = r1_bb;
        n2_lt  = {1'b0, n2_bb} <  n2_aa3;
        n2_le  = {1'b0, n2_bb} <= n2_aa3;
        n2_up  = (r1_b > 16'sd0) || (r1_b == 16'sd0 && r1_a > 16'sd0);
        priority if (r1_a == 16'sd0 && r1_b == 16'sd0) begin
            n2_s = SEC_0;
        end else if (n2_up) begin
            priority if (r1_a > 16'sd0 && n2_lt) begin
                n2_s = SEC_0;
            end else if (r1_a < 16'sd0 && n2_le) begin
                n2_s = SEC_2;
            end else begin
                n2_s = SEC_1;
            end
        end else begin
            priority if (r1_a < 16'sd0 && n2_lt) begin
                n2_s = SEC_3;
            end else if (r1_a > 16'sd0 && n2_le) begin
                n2_s = SEC_5;
            end else begin
                n2_s = SEC_4;
            end
        end
        n2_av = (NW'(r1_a) <<< 17) + (NW'(r1_a) <<< 16);
        n2_bv = NW'(r1_bq);
        unique case (n2_s)
            SEC_0: begin n2_n1s = n2_av - n2_bv;  n2_n2s = n2_bv <<< 1;    end
            SEC_1: begin n2_n1s = n2_av + n2_bv;  n2_n2s = n2_bv - n2_av;  end
            SEC_2: begin n2_n1s = n2_bv <<< 1;    n2_n2s = -n2_av - n2_bv; end
            SEC_3: begin n2_n1s = n2_bv - n2_av;  n2_n2s = -(n2_bv <<< 1); end
            SEC_4: begin n2_n1s = -n2_av - n2_bv; n2_n2s = n2_av - n2_bv;  end
            SEC_5: begin n2_n1s = -(n2_bv <<< 1); n2_n2s = n2_av + n2_bv;  end
            default: begin n2_n1s = '0; n2_n2s = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_a   <= r1_a;
            r2_b   <= r1_b;
            r2_s   <= n2_s;
            r2_n1s <= n2_n1s;
            r2_n2s <= n2_n2s;
        end
    end

    // stage 3
    always_comb begin
        n3_n1   = r2_n1s[NW-1] ? '0 : r2_n1s[NW-2:0];
        n3_n2   = r2_n2s[NW-1] ? '0 : r2_n2s[NW-2:0];
        n3_dsel = (r_bus == '0) ? 16'd1 : r_bus;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_a    <= r2_a;
            r3_b    <= r2_b;
            r3_s    <= r2_s;
            r3_n1   <= n3_n1;
            r3_nsum <= {1'b0, n3_n1} + {1'b0, n3_n2};
            r3_dsel <= n3_dsel;
            r3_d    <= {n3_dsel, 17'd0};
        end
    end

    // stage 4
    always_comb begin
        n4_lim = r3_nsum > NW'(r3_d);
        n4_ma  = r3_a[15] ? 16'(-r3_a) : 16'(r3_a);
        n4_mb  = r3_b[15] ? 16'(-r3_b) : 16'(r3_b);
        n4_pa  = n4_ma * r3_dsel;
        n4_pb  = n4_mb * r3_dsel;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_pl.alpha  <= r3_a;
            r4_pl.beta   <= r3_b;
            r4_pl.sector <= r3_s;
            r4_pl.lim    <= n4_lim;
            r4_den       <= n4_lim ? r3_nsum : NW'(r3_d);
            r4_num[0]    <= NUMW'(r_period * r3_n1);
            r4_num[1]    <= n4_lim ? NUMW'({n4_pa, 17'd0})
                                   : NUMW'(r_period * r3_nsum[32:0]);
            r4_num[2]    <= NUMW'({n4_pb, 17'd0});
        end
    end

    // divider: one quotient bit per stage, three lanes
    always_comb begin
        logic [NUMW-1:0] sh;
        for (int j = 0; j < DIV_STAGES; j++) begin
            sh = NUMW'(r_dv_den[j]) << (QW - 1 - j);
            for (int l = 0; l < LANES; l++) begin
                n_dv_q[j][l] = r_dv_q[j][l];
                if (r_dv_rem[j][l] >= sh) begin
                    n_dv_rem[j][l]          = r_dv_rem[j][l] - sh;
                    n_dv_q[j][l][QW-1-j]    = 1'b1;
                end else begin
                    n_dv_rem[j][l]          = r_dv_rem[j][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_pl[0]  <= r4_pl;
            r_dv_den[0] <= r4_den;
            for (int l = 0; l < LANES; l++) begin
                r_dv_rem[0][l] <= r4_num[l] + NUMW'(r4_den >> 1);
                r_dv_q[0][l]   <= '0;
            end
            for (int j = 0; j < DIV_STAGES; j++) begin
                r_dv_pl[j+1]  <= r_dv_pl[j];
                r_dv_den[j+1] <= r_dv_den[j];
                for (int l = 0; l < LANES; l++) begin
                    r_dv_rem[j+1][l] <= n_dv_rem[j][l];
                    r_dv_q[j+1][l]   <= n_dv_q[j][l];
                end
            end
        end
    end

    // final dwell, limit and on-time
    always_comb begin
        n_pl    = r_dv_pl[DIV_STAGES];
        n_q0    = r_dv_q[DIV_STAGES][0];
        n_q1    = r_dv_q[DIV_STAGES][1];
        n_q2    = r_dv_q[DIV_STAGES][2];
        n_per17 = {1'b0, r_period};
        n_v1    = first_vec(n_pl.sector);
        n_v2    = second_vec(n_pl.sector);
        if (n_pl.lim) begin
            n_tot = n_per17;
            n_t1  = (n_q0 > n_per17) ? r_period : n_q0[15:0];
            n_oa  = n_pl.alpha[15] ? 16'(-n_q1) : 16'(n_q1);
            n_ob  = n_pl.beta[15]  ? 16'(-n_q2) : 16'(n_q2);
        end else begin
            n_tot = (n_q1 > n_per17) ? n_per17 : n_q1;
            n_t1  = (n_q0 > n_tot) ? n_tot[15:0] : n_q0[15:0];
            n_oa  = n_pl.alpha;
            n_ob  = n_pl.beta;
        end
        n_t2 = n_tot[15:0] - n_t1;
        n_t0 = r_period - n_t1 - n_t2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_sector <= n_pl.sector;
            r_out_v1     <= n_v1;
            r_out_v2     <= n_v2;
            r_out_t1     <= n_t1;
            r_out_t2     <= n_t2;
            r_out_t0     <= n_t0;
            r_out_ona    <= (n_v1[2] ? n_t1 : 16'd0) + (n_v2[2] ? n_t2 : 16'd0);
            r_out_onb    <= (n_v1[1] ? n_t1 : 16'd0) + (n_v2[1] ? n_t2 : 16'd0);
            r_out_onc    <= (n_v1[0] ? n_t1 : 16'd0) + (n_v2[0] ? n_t2 : 16'd0);
            r_out_alpha  <= n_oa;
            r_out_beta   <= n_ob;
            r_out_lim    <= n_pl.lim;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j <= DIV_STAGES; j++) begin
                r_dv_valid[j] <= 1'b0;
            end
        end else if (w_en) begin
            r_v1          <= i_s_axis_tvalid;
            r_v2          <= r_v1;
            r_v3          <= r_v2;
            r_v4          <= r_v3;
            r_dv_valid[0] <= r_v4;
            for (int j = 0; j < DIV_STAGES; j++) begin
                r_dv_valid[j+1] <= r_dv_valid[j];
            end
            r_out_valid   <= r_dv_valid[DIV_STAGES];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_lim, r_out_beta, r_out_alpha,
                              r_out_onc, r_out_onb, r_out_ona,
                              r_out_t0, r_out_t2, r_out_t1,
                              r_out_v2, r_out_v1, r_out_sector};

`include "space_vector_pwm_modulator_assert.svh"

    `SVPWM_ASSERT_NOW(a_dwell_sum, i_clk, i_rst_n, r_out_valid,
        16'(r_out_t1 + r_out_t2 + r_out_t0) == r_period)
    `SVPWM_ASSERT_NOW(a_lim_no_zero, i_clk, i_rst_n, r_out_valid && r_out_lim,
        r_out_t0 == 16'd0)
    `SVPWM_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_out_valid && !i_m_axis_tready,
        r_out_valid && $stable(r_out_t1) && $stable(r_out_sector))

endmodule

`default_nettype wire
